// ----- rtl/core/four_level_page_table_walker_core_defines.svh -----
// ----------------------------------------------------------------------------
// Four-level page table walker assertion macros
// Shared property macros for the walker core; empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_CORE_DEFINES_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define FLTW_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fltw assertion failed");
`define FLTW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fltw assertion failed");
`else
`define FLTW_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define FLTW_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/core/fltw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page table walker package
// Request and response types, status and operation codes, shared helpers.
// ----------------------------------------------------------------------------
package fltw_pkg;

    localparam int DEFAULT_TABLE_FRAMES = 64;
    localparam int ENTRIES_PER_TABLE    = 512;
    localparam int INDEX_W              = 9;
    localparam int OFFSET_W             = 12;
    localparam int ENTRY_W              = 64;
    localparam int PADDR_W              = 52;
    localparam int VADDR_W              = 64;
    localparam int STATUS_W             = 2;
    localparam int LEVEL_W              = 2;
    localparam int PFN_W                = PADDR_W - OFFSET_W;

    localparam logic [LEVEL_W-1:0] LAST_LEVEL = 2'd3;

    localparam logic OP_TRANSLATE = 1'b0;
    localparam logic OP_MAP       = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_PRESENT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_FRAMES   = 2'd2;

    typedef struct packed {
        logic               operation;
        logic [VADDR_W-1:0] virtual_address;
        logic [PADDR_W-1:0] physical_address;
    } req_t;

    typedef struct packed {
        logic [PADDR_W-1:0]  translated_address;
        logic [STATUS_W-1:0] status;
    } rsp_t;

    // Finished walk handed from the walker to the output stage.
    typedef struct packed {
        logic valid;
        rsp_t rsp;
    } walk_result_t;

    // Table index of one level: level 0 is the root.
    function automatic logic [INDEX_W-1:0] level_index(input logic [VADDR_W-1:0] va,
                                                       input logic [LEVEL_W-1:0] level);
        logic [INDEX_W-1:0] idx;
        case (level)
            2'd0:    idx = va[47:39];
            2'd1:    idx = va[38:30];
            2'd2:    idx = va[29:21];
            default: idx = va[20:12];
        endcase
        return idx;
    endfunction

endpackage

// ----- rtl/core/four_level_page_table_walker_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Four-level page table walker core
// Translates and maps virtual pages in an internal four-level page table.
// ----------------------------------------------------------------------------
// After reset the core clears all TABLE_FRAMES * 512 entries of its frame
// store (32768 at the default), with s_ready low. It then serves one request
// at a time from a single-port table memory: each level read takes a read
// state (address) and an evaluation state (the registered entry), and a done
// state hands the response to the output register. A translate reads levels
// until an entry is missing or all four levels are read. A map reads the
// inner levels, checks for free frames, writes one entry per missing table
// plus one for the leaf, and hands over the response. The walker is idle
// again, and takes the next request, in the cycle after the response is
// loaded; it waits in the done state while the output register is full and
// m_ready is low.
// A finished result waits in an output register, so the next request is
// taken while it is still pending.
`include "four_level_page_table_walker_core_defines.svh"

module four_level_page_table_walker_core
    import fltw_pkg::*;
#(
    parameter int TABLE_FRAMES = DEFAULT_TABLE_FRAMES
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_req,
    output logic m_valid,
    input  logic m_ready,
    output rsp_t m_rsp
);

    walk_result_t walk_result;
    logic         out_free;
    logic         m_valid_reg, m_valid_next;
    rsp_t         m_rsp_reg, m_rsp_next;

    fltw_walker #(
        .TABLE_FRAMES (TABLE_FRAMES)
    ) u_walker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_req    (s_req),
        .out_free (out_free),
        .result   (walk_result)
    );

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_rsp_next   = m_rsp_reg;
        if (walk_result.valid && out_free) begin
            m_valid_next = 1'b1;
            m_rsp_next   = walk_result.rsp;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_rsp_reg <= m_rsp_next;
    end

    assign m_valid = m_valid_reg;
    assign m_rsp   = m_rsp_reg;

    `FLTW_ASSERT_IMPLIES(a_status_legal, aclk, aresetn, m_valid, m_rsp.status <= STATUS_NO_FRAMES)
    `FLTW_ASSERT_IMPLIES(a_fail_zero_addr, aclk, aresetn, m_valid && m_rsp.status != STATUS_OK, m_rsp.translated_address == '0)
    `FLTW_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)

endmodule

// ----- rtl/core/fltw_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or one write per cycle; read data is registered.
// ----------------------------------------------------------------------------
module fltw_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 512,
    parameter int ADDR_W = 9
) (
    input  logic              clk,
    input  logic              re,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[addr] <= wdata;
        end else if (re) begin
            rdata <= mem[addr];
        end
    end

endmodule

// ----- rtl/core/fltw_walker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page table walk sequencer
// Clears the frame store, walks the levels and allocates missing tables.
// ----------------------------------------------------------------------------
module fltw_walker
    import fltw_pkg::*;
#(
    parameter int TABLE_FRAMES = DEFAULT_TABLE_FRAMES
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  req_t         s_req,
    input  logic         out_free,
    output walk_result_t result
);

    localparam int FIDX_W = (TABLE_FRAMES > 1) ? $clog2(TABLE_FRAMES) : 1;
    localparam int NF_W   = $clog2(TABLE_FRAMES + 1);
    localparam int ADDR_W = FIDX_W + INDEX_W;
    localparam int DEPTH  = TABLE_FRAMES * ENTRIES_PER_TABLE;
    localparam int CMP_W  = NF_W + LEVEL_W;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [NF_W-1:0]   NF_LIMIT  = NF_W'(TABLE_FRAMES);
    localparam logic [PFN_W-1:0]  PFN_LIMIT = PFN_W'(TABLE_FRAMES);

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_READ  = 7'b0000100,
        ST_EVAL  = 7'b0001000,
        ST_CHECK = 7'b0010000,
        ST_WRITE = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    state_t               state_reg, state_next;
    req_t                 req_reg, req_next;
    logic [LEVEL_W-1:0]   level_reg, level_next;
    logic [FIDX_W-1:0]    frame_reg, frame_next;
    logic [NF_W-1:0]      nf_reg, nf_next;
    logic [ADDR_W-1:0]    clr_addr_reg, clr_addr_next;
    rsp_t                 rsp_reg, rsp_next;

    logic                 ram_re;
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_addr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [ENTRY_W-1:0]   ram_rdata;

    logic [ADDR_W-1:0]    walk_addr;
    logic [PFN_W-1:0]     entry_pfn;
    logic                 entry_present;
    logic                 entry_follow;
    logic [NF_W-1:0]      frames_avail;
    logic [LEVEL_W-1:0]   levels_missing;

    fltw_ram #(
        .WIDTH  (ENTRY_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk   (aclk),
        .re    (ram_re),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign walk_addr     = {frame_reg, level_index(req_reg.virtual_address, level_reg)};
    assign entry_pfn     = ram_rdata[PADDR_W-1:OFFSET_W];
    assign entry_present = ram_rdata[0];
    // A pointer beyond the frame store counts as not present.
    assign entry_follow  = entry_present && (entry_pfn < PFN_LIMIT);

    assign frames_avail   = (nf_reg <= NF_LIMIT) ? (NF_LIMIT - nf_reg) : '0;
    assign levels_missing = LAST_LEVEL - level_reg;

    assign s_ready    = (state_reg == ST_IDLE);
    assign result.valid = (state_reg == ST_DONE);
    assign result.rsp   = rsp_reg;

    always_comb begin
        ram_re    = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = walk_addr;
        ram_wdata = '0;
        case (state_reg)
            ST_CLEAR: begin
                ram_we   = 1'b1;
                ram_addr = clr_addr_reg;
            end
            ST_READ: begin
                ram_re = 1'b1;
            end
            ST_WRITE: begin
                ram_we = 1'b1;
                if (level_reg != LAST_LEVEL) begin
                    ram_wdata = {{(ENTRY_W - PADDR_W){1'b0}}, PFN_W'(nf_reg),
                                 {(OFFSET_W - 2){1'b0}}, 2'b11};
                end else begin
                    ram_wdata = {{(ENTRY_W - PADDR_W){1'b0}},
                                 req_reg.physical_address[PADDR_W-1:OFFSET_W],
                                 {(OFFSET_W - 2){1'b0}}, 2'b11};
                end
            end
            default: begin
                ram_re = 1'b0;
            end
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        req_next      = req_reg;
        level_next    = level_reg;
        frame_next    = frame_reg;
        nf_next       = nf_reg;
        clr_addr_next = clr_addr_reg;
        rsp_next      = rsp_reg;
        case (state_reg)
            ST_CLEAR: begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_ADDR) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    req_next   = s_req;
                    level_next = '0;
                    frame_next = '0;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                if (level_reg == LAST_LEVEL) begin
                    // Leaf of a translate.
                    if (entry_present) begin
                        rsp_next.translated_address =
                            {entry_pfn, req_reg.virtual_address[OFFSET_W-1:0]};
                        rsp_next.status = STATUS_OK;
                    end else begin
                        rsp_next.translated_address = '0;
                        rsp_next.status = STATUS_NOT_PRESENT;
                    end
                    state_next = ST_DONE;
                end else if (entry_follow) begin
                    frame_next = FIDX_W'(entry_pfn);
                    level_next = level_reg + 1'b1;
                    if (req_reg.operation == OP_MAP && level_reg == LAST_LEVEL - 1'b1) begin
                        state_next = ST_CHECK;
                    end else begin
                        state_next = ST_READ;
                    end
                end else if (req_reg.operation == OP_MAP) begin
                    state_next = ST_CHECK;
                end else begin
                    rsp_next.translated_address = '0;
                    rsp_next.status = STATUS_NOT_PRESENT;
                    state_next = ST_DONE;
                end
            end
            ST_CHECK: begin
                rsp_next.translated_address = '0;
                if (CMP_W'(levels_missing) > CMP_W'(frames_avail)) begin
                    rsp_next.status = STATUS_NO_FRAMES;
                    state_next = ST_DONE;
                end else begin
                    rsp_next.status = STATUS_OK;
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (level_reg != LAST_LEVEL) begin
                    frame_next = FIDX_W'(nf_reg);
                    nf_next    = nf_reg + 1'b1;
                    level_next = level_reg + 1'b1;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            nf_reg       <= NF_W'(1);
            clr_addr_reg <= '0;
            level_reg    <= '0;
            frame_reg    <= '0;
        end else begin
            state_reg    <= state_next;
            nf_reg       <= nf_next;
            clr_addr_reg <= clr_addr_next;
            level_reg    <= level_next;
            frame_reg    <= frame_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg <= req_next;
        rsp_reg <= rsp_next;
    end

endmodule

// ----- verif/four_level_page_table_walker_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Four-level page table walker core testbench
// A short table of directed requests followed by mostly well-formed random
// translates and maps; every response is checked against a fixed expected
// response or a behavioral model of the page table that the testbench keeps.
// ----------------------------------------------------------------------------
module four_level_page_table_walker_core_test;
    import fltw_pkg::*;

    localparam int TABLE_FRAMES  = DEFAULT_TABLE_FRAMES;
    localparam int RANDOM_ITEMS  = 1280;
    localparam int POOL_DEPTH    = 256;
    localparam int DRAIN_CYCLES  = 40;
    localparam int CYCLE_LIMIT   = 600000;
    localparam logic [ENTRY_W-1:0] ENTRY_FLAGS = 64'h3;   // present | writable

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    req_t s_req   = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    rsp_t m_rsp;

    // Testbench copy of the page table and the frame allocator.
    bit [ENTRY_W-1:0] page_tables [TABLE_FRAMES*ENTRIES_PER_TABLE];
    int unsigned next_table_frame = 1;

    rsp_t pending_rsps [$];
    logic [VADDR_W-1:0] mapped_vas [$];

    typedef struct {
        req_t req;
        bit   typed;
        rsp_t rsp;
    } walk_row_t;
    walk_row_t walk_rows [$];

    bit quiet = 1'b0;
    int error_count   = 0;
    int cycle_count   = 0;
    int translate_count = 0;
    int map_count     = 0;
    int hit_count     = 0;
    int miss_count    = 0;
    int refused_count = 0;

    four_level_page_table_walker_core #(
        .TABLE_FRAMES(TABLE_FRAMES)
    ) u_top (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_req  (s_req),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_rsp  (m_rsp)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("four_level_page_table_walker_core test failed");
            $finish;
        end
    end

    // Walks the table for one request and applies a map to the copy.
    function automatic rsp_t predict_walk(input req_t r);
        logic [INDEX_W-1:0] idx [4];
        int unsigned frame;
        int unsigned level;
        int unsigned missing;
        int unsigned avail;
        int unsigned nf;
        logic [ENTRY_W-1:0] e;
        bit walking;
        rsp_t p;
        idx[0] = r.virtual_address[47:39];
        idx[1] = r.virtual_address[38:30];
        idx[2] = r.virtual_address[29:21];
        idx[3] = r.virtual_address[20:12];
        frame = 0;
        level = 0;
        walking = 1'b1;
        while (walking && level < 3) begin
            e = page_tables[frame*ENTRIES_PER_TABLE + idx[level]];
            if (e[0] && e[51:12] < TABLE_FRAMES) begin
                frame = 32'(e[51:12]);
                level++;
            end else begin
                walking = 1'b0;
            end
        end
        p.translated_address = '0;
        p.status = STATUS_OK;
        if (r.operation == OP_TRANSLATE) begin
            if (level < 3) begin
                p.status = STATUS_NOT_PRESENT;
            end else begin
                e = page_tables[frame*ENTRIES_PER_TABLE + idx[3]];
                if (e[0]) begin
                    p.translated_address = {e[51:12], r.virtual_address[11:0]};
                end else begin
                    p.status = STATUS_NOT_PRESENT;
                end
            end
        end else begin
            missing = 3 - level;
            avail = (next_table_frame <= TABLE_FRAMES) ? TABLE_FRAMES - next_table_frame : 0;
            if (missing > avail) begin
                p.status = STATUS_NO_FRAMES;
            end else begin
                while (level < 3) begin
                    nf = next_table_frame;
                    next_table_frame++;
                    page_tables[frame*ENTRIES_PER_TABLE + idx[level]] =
                        (64'(nf) << OFFSET_W) | ENTRY_FLAGS;
                    frame = nf;
                    level++;
                end
                page_tables[frame*ENTRIES_PER_TABLE + idx[3]] =
                    {12'b0, r.physical_address[51:12], 12'b0} | ENTRY_FLAGS;
            end
        end
        return p;
    endfunction

    // Mostly requests that land in tables already built, with some noise.
    function automatic req_t make_walk_request();
        req_t r;
        logic [63:0] va;
        logic [63:0] pa_bits;
        logic [63:0] base;
        int kind;
        va = {$urandom, $urandom};
        pa_bits = {$urandom, $urandom};
        kind = $urandom_range(99);
        if (mapped_vas.size() == 0) kind = 99;
        base = (mapped_vas.size() != 0) ? mapped_vas[$urandom_range(mapped_vas.size()-1)]
                                        : 64'd0;
        r.physical_address = pa_bits[51:0];
        r.operation = OP_TRANSLATE;
        if (kind < 35) begin
            r.virtual_address = {va[63:48], base[47:12], va[11:0]};
        end else if (kind < 45) begin
            r.virtual_address = {va[63:48], base[47:21], va[20:0]};
        end else if (kind < 55) begin
            r.virtual_address = va;
        end else begin
            r.operation = OP_MAP;
            if (kind < 80) begin
                va = {va[63:48], base[47:21], va[20:0]};
            end else if (kind < 85) begin
                va = {va[63:48], base[47:12], va[11:0]};
            end else if (kind < 88) begin
                va = {va[63:48], base[47:30], va[29:0]};
            end else if (kind < 91) begin
                va = {va[63:48], base[47:39], va[38:0]};
            end
            r.virtual_address = va;
        end
        return r;
    endfunction

    task automatic add_row(input logic op, input logic [VADDR_W-1:0] va,
                           input logic [PADDR_W-1:0] pa, input bit typed,
                           input logic [PADDR_W-1:0] ta, input logic [STATUS_W-1:0] st);
        walk_row_t row;
        row.req.operation = op;
        row.req.virtual_address = va;
        row.req.physical_address = pa;
        row.typed = typed;
        row.rsp.translated_address = ta;
        row.rsp.status = st;
        walk_rows.push_back(row);
    endtask

    task automatic issue_request(input req_t r, input bit typed, input rsp_t typed_rsp);
        rsp_t p;
        if (!quiet) begin
            while ($urandom_range(99) < 10) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_req <= r;
        do @(posedge aclk); while (!s_ready);
        p = predict_walk(r);
        pending_rsps.push_back(typed ? typed_rsp : p);
        if (r.operation == OP_TRANSLATE) begin
            translate_count++;
            if (p.status == STATUS_OK) hit_count++;
            else miss_count++;
        end else begin
            map_count++;
            if (p.status == STATUS_NO_FRAMES) begin
                refused_count++;
            end else if (mapped_vas.size() < POOL_DEPTH) begin
                mapped_vas.push_back(r.virtual_address);
            end else begin
                mapped_vas[$urandom_range(POOL_DEPTH-1)] = r.virtual_address;
            end
        end
    endtask

    always @(posedge aclk) begin
        rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_rsps.size() == 0) begin
                error_count++;
                $display("%0t: response with none expected: expected none, actual %h",
                         $time, m_rsp);
            end else begin
                want = pending_rsps.pop_front();
                if (m_rsp.translated_address !== want.translated_address) begin
                    error_count++;
                    $display("%0t: translated_address mismatch: expected %h, actual %h",
                             $time, want.translated_address, m_rsp.translated_address);
                end
                if (m_rsp.status !== want.status) begin
                    error_count++;
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, want.status, m_rsp.status);
                end
            end
        end
        m_ready <= quiet || ($urandom_range(99) >= 10);
    end

    initial begin
        int i;
        // Translates on an empty table, maps at both ends of the address space,
        // ignored upper bits, remapping and misses at levels 0, 2 and 3.
        add_row(OP_TRANSLATE, 64'h0, 52'h0, 1, 52'h0, STATUS_NOT_PRESENT);
        add_row(OP_TRANSLATE, '1, '1, 1, 52'h0, STATUS_NOT_PRESENT);
        add_row(OP_MAP, 64'h0, '1, 1, 52'h0, STATUS_OK);
        add_row(OP_TRANSLATE, 64'h0000_0000_0000_0FFF, 52'h0, 0, '0, '0);
        add_row(OP_MAP, '1, 52'h0, 1, 52'h0, STATUS_OK);
        add_row(OP_TRANSLATE, '1, 52'h0, 0, '0, '0);
        add_row(OP_TRANSLATE, 64'hFFFF_0000_0000_0ABC, 52'h0, 0, '0, '0);
        add_row(OP_TRANSLATE, 64'h0000_0000_0000_1000, 52'h0, 1, 52'h0, STATUS_NOT_PRESENT);
        add_row(OP_TRANSLATE, 64'h0000_0000_0020_0000, 52'h0, 1, 52'h0, STATUS_NOT_PRESENT);
        add_row(OP_TRANSLATE, 64'h0000_0080_0000_0000, 52'h0, 1, 52'h0, STATUS_NOT_PRESENT);
        add_row(OP_MAP, 64'h0000_0000_0000_1000, 52'h1_2345_6789_ABC, 1, 52'h0, STATUS_OK);
        add_row(OP_TRANSLATE, 64'h0000_0000_0000_1ABC, 52'h0, 0, '0, '0);
        add_row(OP_MAP, 64'h0, 52'h0_000A_BCDE_000, 1, 52'h0, STATUS_OK);
        add_row(OP_TRANSLATE, 64'h0000_0000_0000_0123, '1, 0, '0, '0);
        add_row(OP_MAP, 64'h0000_0000_4000_5000, 52'hA_AAAA_AAAA_AAAA, 0, '0, '0);
        add_row(OP_TRANSLATE, 64'h0000_0000_4000_5FFF, 52'h0, 0, '0, '0);
        add_row(OP_MAP, 64'hABCD_0080_0000_0000, 52'h5_5555_5555_5555, 0, '0, '0);
        add_row(OP_TRANSLATE, 64'h0000_0080_0000_0FFF, 52'h0, 0, '0, '0);
        add_row(OP_TRANSLATE, 64'h0000_FFFF_FFFF_F000, 52'h0, 0, '0, '0);
        add_row(OP_TRANSLATE, 64'h5555_0000_0000_1001, 52'h0, 0, '0, '0);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (walk_rows[k]) begin
            issue_request(walk_rows[k].req, walk_rows[k].typed, walk_rows[k].rsp);
        end

        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 300) quiet <= 1'b1;
            if (i == 500) quiet <= 1'b0;
            // Let the core drain completely before the next request.
            if (i == 700) begin
                s_valid <= 1'b0;
                @(posedge aclk);
                while (pending_rsps.size() != 0) @(posedge aclk);
            end
            issue_request(make_walk_request(), 1'b0, '0);
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_rsps.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d translates (%0d hits, %0d misses) and %0d maps",
                 translate_count, hit_count, miss_count, map_count);
        $display("%0d maps refused for lack of frames; %0d table frames allocated",
                 refused_count, next_table_frame - 1);
        if (error_count == 0) begin
            $display("four_level_page_table_walker_core test passed");
        end else begin
            $display("four_level_page_table_walker_core test failed");
        end
        $finish;
    end

endmodule
